FILE: rtl/oaid_pkg.sv
// oaid_pkg: shared types and codes for the ordered array insert/delete block
// used by ordered_array_insert_delete; no dependencies
`default_nettype none

package oaid_pkg;

  // field widths fixed by the interface
  localparam int unsigned OpBits     = 3;
  localparam int unsigned CountBits  = 5;
  localparam int unsigned StatusBits = 2;

  typedef enum logic [OpBits-1:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_READ   = 3'd2,
    OP_DELETE = 3'd3,
    OP_EDIT   = 3'd4
  } op_t;

  typedef enum logic [StatusBits-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_INDEX = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_LAST,
    ST_PUT,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/oaid_ram.sv
// oaid_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module oaid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/ordered_array_insert_delete.sv
// ordered_array_insert_delete: bounded ordered list with insert, append, read,
// delete and edit; depends on oaid_pkg and oaid_ram
`default_nettype none

// An item is taken when start is high and busy is low. Exactly one result
// follows per item, shown for one cycle with done high; the receiver cannot
// stall it. Append, edit, a failed operation, an unknown opcode, an insert at
// the end and a delete of the last entry finish at once (done on the cycle
// after the transfer). A read passes through ST_READ before done, because
// the entry store has a registered read port. Insert and delete move entries
// one per cycle through the single write port of the store: ST_MOVE reads
// each source entry and writes back the one read before it (pipeline fill),
// ST_LAST drains the final entry, and for insert ST_PUT writes the new word
// last. The list empties on reset and on any write of the capacity register;
// a capacity of 0 behaves as 1 and one above MAX_ENTRIES behaves as MAX_ENTRIES.
module ordered_array_insert_delete #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned WORD_BITS   = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // capacity register write
  input  wire logic                                cfg_we,
  input  wire logic        [oaid_pkg::CountBits-1:0] cfg_data,
  // command side
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic        [oaid_pkg::OpBits-1:0]  opcode,
  input  wire logic        [oaid_pkg::CountBits-1:0] index,
  input  wire logic signed [WORD_BITS-1:0]         data,
  // result side
  output logic                                     done,
  output logic signed      [WORD_BITS-1:0]         read_data,
  output logic             [oaid_pkg::StatusBits-1:0] status,
  output logic             [oaid_pkg::CountBits-1:0] entry_count,
  output logic                                     is_empty,
  output logic                                     is_full
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = oaid_pkg::CountBits;

  // control state
  oaid_pkg::state_t  state, state_next;
  logic [CW-1:0]     capacity;
  logic [CW-1:0]     count, count_next;
  logic              pend, pend_next;       // a read is in flight to be written back
  logic              done_next;

  // item and datapath registers
  oaid_pkg::op_t     op_r, op_r_next;
  logic [CW-1:0]     pos_r, pos_r_next;
  logic [WORD_BITS-1:0] word_r, word_r_next;
  logic [CW-1:0]     cursor, cursor_next;   // next source entry to read
  logic [CW-1:0]     stop, stop_next;       // last source entry of the move
  logic [CW-1:0]     pend_addr, pend_addr_next;
  logic [WORD_BITS-1:0] rdata, rdata_next;
  oaid_pkg::status_t status_r, status_next;

  // ram port
  logic                 ram_we;
  logic [CW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [CW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // effective capacity with saturation at both ends
  logic [CW-1:0] cap_eff;
  logic          list_full;
  logic          accept;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (32'(capacity) > 32'(MAX_ENTRIES)) begin
      cap_eff = CW'(MAX_ENTRIES);
    end else begin
      cap_eff = capacity;
    end
  end

  assign list_full = (count >= cap_eff);
  assign busy      = (state != oaid_pkg::ST_IDLE);
  assign accept    = start && !busy;

  oaid_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (AW'(ram_waddr)),
    .wr_data (ram_wdata),
    .rd_addr (AW'(ram_raddr)),
    .rd_data (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      oaid_pkg::ST_IDLE: begin
        if (accept) begin
          case (oaid_pkg::op_t'(opcode))
            oaid_pkg::OP_INSERT: begin
              if (index < count && !list_full) begin
                state_next = oaid_pkg::ST_MOVE;
              end
            end
            oaid_pkg::OP_READ: begin
              if (index < count) begin
                state_next = oaid_pkg::ST_READ;
              end
            end
            oaid_pkg::OP_DELETE: begin
              // index checked first so a far index cannot wrap into a move
              if (index < count && index + CW'(1) < count) begin
                state_next = oaid_pkg::ST_MOVE;
              end
            end
            default: state_next = oaid_pkg::ST_IDLE;
          endcase
        end
      end
      oaid_pkg::ST_MOVE: begin
        if (cursor == stop) begin
          state_next = oaid_pkg::ST_LAST;
        end
      end
      oaid_pkg::ST_LAST: begin
        state_next = (op_r == oaid_pkg::OP_INSERT) ? oaid_pkg::ST_PUT : oaid_pkg::ST_IDLE;
      end
      oaid_pkg::ST_PUT:  state_next = oaid_pkg::ST_IDLE;
      oaid_pkg::ST_READ: state_next = oaid_pkg::ST_IDLE;
      default:           state_next = oaid_pkg::ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    count_next     = count;
    pend_next      = pend;
    done_next      = 1'b0;
    op_r_next      = op_r;
    pos_r_next     = pos_r;
    word_r_next    = word_r;
    cursor_next    = cursor;
    stop_next      = stop;
    pend_addr_next = pend_addr;
    rdata_next     = rdata;
    status_next    = status_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_addr;
    ram_wdata      = ram_rdata;
    ram_raddr      = cursor;
    case (state)
      oaid_pkg::ST_IDLE: begin
        ram_raddr   = index;
        op_r_next   = oaid_pkg::op_t'(opcode);
        pos_r_next  = index;
        word_r_next = data;
        pend_next   = 1'b0;
        if (accept) begin
          rdata_next  = '0;
          status_next = oaid_pkg::STAT_OK;
          done_next   = 1'b1;
          case (oaid_pkg::op_t'(opcode))
            oaid_pkg::OP_INSERT: begin
              if (index > count) begin
                status_next = oaid_pkg::STAT_BAD_INDEX;
              end else if (list_full) begin
                status_next = oaid_pkg::STAT_OVERFLOW;
              end else if (index == count) begin
                // insert at the end needs no move
                ram_we     = 1'b1;
                ram_waddr  = index;
                ram_wdata  = data;
                count_next = count + CW'(1);
              end else begin
                // move down from the top entry to index
                done_next   = 1'b0;
                cursor_next = count - CW'(1);
                stop_next   = index;
              end
            end
            oaid_pkg::OP_APPEND: begin
              if (list_full) begin
                status_next = oaid_pkg::STAT_OVERFLOW;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = count;
                ram_wdata  = data;
                count_next = count + CW'(1);
              end
            end
            oaid_pkg::OP_READ: begin
              if (index >= count) begin
                status_next = oaid_pkg::STAT_BAD_INDEX;
                rdata_next  = '1;
              end else begin
                done_next = 1'b0;
              end
            end
            oaid_pkg::OP_DELETE: begin
              if (index >= count) begin
                status_next = oaid_pkg::STAT_BAD_INDEX;
              end else if (index + CW'(1) == count) begin
                // last entry just drops off
                count_next = count - CW'(1);
              end else begin
                done_next   = 1'b0;
                cursor_next = index + CW'(1);
                stop_next   = count - CW'(1);
              end
            end
            oaid_pkg::OP_EDIT: begin
              if (index >= count) begin
                status_next = oaid_pkg::STAT_BAD_INDEX;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = index;
                ram_wdata = data;
              end
            end
            default: status_next = oaid_pkg::STAT_OK;
          endcase
        end
      end
      oaid_pkg::ST_MOVE: begin
        // read cursor now, write back the entry read last cycle
        ram_we    = pend;
        pend_next = 1'b1;
        if (op_r == oaid_pkg::OP_INSERT) begin
          pend_addr_next = cursor + CW'(1);
          cursor_next    = cursor - CW'(1);
        end else begin
          pend_addr_next = cursor - CW'(1);
          cursor_next    = cursor + CW'(1);
        end
      end
      oaid_pkg::ST_LAST: begin
        ram_we    = 1'b1;
        pend_next = 1'b0;
        if (op_r != oaid_pkg::OP_INSERT) begin
          count_next = count - CW'(1);
          done_next  = 1'b1;
        end
      end
      oaid_pkg::ST_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = pos_r;
        ram_wdata  = word_r;
        count_next = count + CW'(1);
        done_next  = 1'b1;
      end
      oaid_pkg::ST_READ: begin
        rdata_next = ram_rdata;
        done_next  = 1'b1;
      end
      default: done_next = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= oaid_pkg::ST_IDLE;
      capacity <= CW'(16);
      count    <= '0;
      pend     <= 1'b0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      done  <= done_next;
      if (cfg_we) begin
        // a capacity write empties the list
        capacity <= cfg_data;
        count    <= '0;
      end else begin
        count <= count_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_r_next;
    pos_r     <= pos_r_next;
    word_r    <= word_r_next;
    cursor    <= cursor_next;
    stop      <= stop_next;
    pend_addr <= pend_addr_next;
    rdata     <= rdata_next;
    status_r  <= status_next;
  end

  assign read_data   = rdata;
  assign status      = status_r;
  assign entry_count = count;
  assign is_empty    = (count == '0);
  assign is_full     = (count == cap_eff);

  // the stored count never exceeds what the capacity allows
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cap_eff)
    else $error("entry count above capacity");

  // a result is only shown while no item is in progress
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // a move never ends in a strobe straight from the move loop
  a_move_no_done: assert property (@(posedge clk) disable iff (rst)
    (state == oaid_pkg::ST_MOVE) |=> !done)
    else $error("result strobe during entry move");

  // every write to the store stays within the usable entries
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ram_waddr < cap_eff))
    else $error("store write beyond capacity");

  // the drain state always writes back a pending entry
  a_last_pending: assert property (@(posedge clk) disable iff (rst)
    (state == oaid_pkg::ST_LAST) |-> pend)
    else $error("drain without pending entry");

endmodule

`default_nettype wire
